/* hw/rtl/fol_pkg.sv */
// Shared types and constants for the frequency-ordered list locate block.
// No dependencies; every other file in hw/rtl imports this package.
package fol_pkg;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned COUNT_WIDTH = 16;

    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned USED_W = $clog2(DEPTH + 1);

    // Fixed field widths of the request and result beats
    localparam int unsigned KEY_W    = 8;
    localparam int unsigned IN_IDX_W = 6;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned CNT_OUT_W = 16;

    // Common width for comparing a request index against the fill count
    localparam int unsigned CMP_W = (USED_W > IN_IDX_W) ? USED_W : IN_IDX_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_LOCATE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_APPENDED = 2'd1,
        ST_FULL     = 2'd2,
        ST_MISS     = 2'd3
    } t_status;

    typedef struct packed {
        t_req                req_type;
        logic [KEY_W-1:0]    key;
        logic [IN_IDX_W-1:0] index;
    } t_in_beat;

    typedef struct packed {
        t_status              status;
        logic [POS_W-1:0]     position;
        logic [KEY_W-1:0]     key_out;
        logic [CNT_OUT_W-1:0] count_out;
    } t_out_beat;

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [COUNT_WIDTH-1:0] count;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_WRITE = 2'd1,
        CELL_MOVE  = 2'd2
    } t_cell_op;

    // Broadcast from the sequencer to every cell of the row
    typedef struct packed {
        t_cell_op          op;
        t_entry            new_entry;  // key to match, count to rank against
        logic [USED_W-1:0] used;
        logic [IDX_W-1:0]  hit;        // where the located entry sits now
        logic [IDX_W-1:0]  ins;        // where the new or moved entry lands
        logic [IDX_W-1:0]  sel_pos;    // entry driven onto the read bus
    } t_cell_ctrl;

endpackage

/* hw/rtl/frequency_ordered_list_locate.sv */
// Frequency-ordered list locate: a table of up to DEPTH byte keys kept as a row
// of cells, each with an access count. Append puts a key at the tail with count
// zero; locate finds the first matching key, bumps its count (saturating) and
// moves it ahead of the first other entry whose count is not greater, so it
// ranks first among equals; a locate that misses appends. Read returns the
// entry at an index. Exactly one result beat per request beat. Read, append
// and a missed locate finish in the match pass; a hit runs the sequencer's
// three passes over the cell row (match, rank, shift), each a broadcast to all
// cells, match and rank also with a tree search; one request at a time.
// A request is taken while a previous result still waits on the output
// register; its last step then waits until that register frees. Table
// contents need no clearing after reset: only entries below the fill count
// are ever looked at. Depends on fol_pkg, fol_cell and fol_prio.
module frequency_ordered_list_locate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fol_pkg::t_in_beat i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fol_pkg::t_out_beat o_out_beat
);
    import fol_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FIND  = 4'b0010,
        S_PLACE = 4'b0100,
        S_MOVE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // request held for the whole item
    t_in_beat r_req;

    logic [USED_W-1:0]      r_used, n_used;
    logic [IDX_W-1:0]       r_hit, n_hit;
    logic [IDX_W-1:0]       r_ins, n_ins;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;

    logic      r_out_valid;
    t_out_beat r_out, n_out;
    logic      out_free, out_load;

    t_cell_ctrl       ctrl;
    t_entry           cell_q   [DEPTH];
    t_entry           cell_sel [DEPTH];
    t_entry           left_in  [DEPTH];
    t_entry           right_in [DEPTH];
    logic [DEPTH-1:0] match, cand;
    t_entry           sel_bus;

    logic             hit_found, cand_found;
    logic [IDX_W-1:0] hit_idx, cand_idx;

    logic full, read_ok, in_accept;

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_row
            if (g == 0) begin : g_head
                assign left_in[g] = '0;
            end else begin : g_mid_l
                assign left_in[g] = cell_q[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_in[g] = '0;
            end else begin : g_mid_r
                assign right_in[g] = cell_q[g+1];
            end

            fol_cell u_cell (
                .i_clk   (i_clk),
                .i_pos   (IDX_W'(g)),
                .i_ctrl  (ctrl),
                .i_left  (left_in[g]),
                .i_right (right_in[g]),
                .o_entry (cell_q[g]),
                .o_sel   (cell_sel[g]),
                .o_match (match[g]),
                .o_cand  (cand[g])
            );
        end
    endgenerate

    // first matching key
    fol_prio u_hit_prio (
        .i_bits  (match),
        .o_found (hit_found),
        .o_idx   (hit_idx)
    );

    // first entry the moved one may land ahead of
    fol_prio u_cand_prio (
        .i_bits  (cand),
        .o_found (cand_found),
        .o_idx   (cand_idx)
    );

    // Read bus: only the selected cell drives non-zero
    always_comb begin
        sel_bus = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_bus = sel_bus | cell_sel[i];
        end
    end

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    assign full    = (r_used == USED_W'(DEPTH));
    assign read_ok = CMP_W'(r_req.index) < CMP_W'(r_used);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_hit    = r_hit;
        n_ins    = r_ins;
        n_cnt    = r_cnt;
        n_out    = r_out;
        out_load = 1'b0;

        ctrl.op              = CELL_HOLD;
        ctrl.new_entry.key   = r_req.key;
        ctrl.new_entry.count = r_cnt;
        ctrl.used            = r_used;
        ctrl.hit             = r_hit;
        ctrl.ins             = r_ins;
        ctrl.sel_pos         = hit_idx;

        case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_FIND;
            end

            S_FIND: begin
                // match pass; read, append and a missed locate finish here
                ctrl.hit             = '0;
                ctrl.new_entry.count = '0;
                ctrl.ins             = IDX_W'(r_used);
                if (r_req.req_type == REQ_READ) begin
                    ctrl.sel_pos = IDX_W'(r_req.index);
                end
                if (r_req.req_type == REQ_LOCATE && hit_found) begin
                    // promote: fetch and bump the count, go rank it
                    n_hit   = hit_idx;
                    n_cnt   = (sel_bus.count == COUNT_MAX) ? sel_bus.count
                                                           : sel_bus.count + 1'b1;
                    n_state = S_PLACE;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    case (r_req.req_type)
                        REQ_APPEND, REQ_LOCATE: begin
                            if (full) begin
                                n_out = '{ST_FULL, '0, r_req.key, '0};
                            end else begin
                                ctrl.op = CELL_WRITE;
                                n_out   = '{ST_APPENDED, POS_W'(r_used), r_req.key, '0};
                                n_used  = r_used + 1'b1;
                            end
                        end
                        REQ_READ: begin
                            if (read_ok) begin
                                n_out = '{ST_FOUND, POS_W'(r_req.index), sel_bus.key,
                                          CNT_OUT_W'(sel_bus.count)};
                            end else begin
                                n_out = '{ST_MISS, POS_W'(r_req.index), '0, '0};
                            end
                        end
                        default: begin
                            n_out = '{ST_MISS, '0, '0, '0};
                        end
                    endcase
                end
            end

            S_PLACE: begin
                // rank pass: landing spot in the list with the entry taken out
                if (!cand_found) begin
                    n_ins = IDX_W'(r_used - 1'b1);
                end else if (cand_idx < r_hit) begin
                    n_ins = cand_idx;
                end else begin
                    n_ins = cand_idx - 1'b1;
                end
                n_state = S_MOVE;
            end

            S_MOVE: begin
                // shift pass: advance or drop back the entries between hit and landing
                if (out_free) begin
                    ctrl.op  = CELL_MOVE;
                    out_load = 1'b1;
                    n_out    = '{ST_FOUND, POS_W'(r_ins), r_req.key, CNT_OUT_W'(r_cnt)};
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_req <= i_in_beat;
        r_hit <= n_hit;
        r_ins <= n_ins;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(DEPTH))
        else $error("fill count beyond table depth");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_used != $past(r_used))
            |-> (r_out_valid && r_out.status == ST_APPENDED))
        else $error("fill count changed without an append result");

    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_state == S_MOVE)
            |-> ($past(r_state) == S_PLACE || $past(r_state) == S_MOVE))
        else $error("shift pass entered without a rank pass");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == S_IDLE && r_out_valid))
        else $error("result loaded but sequencer did not return to idle");

endmodule

/* hw/rtl/fol_prio.sv */
// First-set-bit finder over the cell row, built as a balanced tree.
// Depends on fol_pkg.
module fol_prio (
    input  logic [fol_pkg::DEPTH-1:0] i_bits,
    output logic                      o_found,
    output logic [fol_pkg::IDX_W-1:0] o_idx
);
    import fol_pkg::*;

    localparam int unsigned LEAVES = 2 ** IDX_W;

    logic [2*LEAVES-1:1] node_v;
    logic [IDX_W-1:0]    node_i [1:2*LEAVES-1];

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++) begin : g_leaf
            if (g < DEPTH) begin : g_real
                assign node_v[LEAVES+g] = i_bits[g];
            end else begin : g_pad
                assign node_v[LEAVES+g] = 1'b0;
            end
            assign node_i[LEAVES+g] = IDX_W'(g);
        end
        for (g = 1; g < LEAVES; g++) begin : g_node
            // prefer the lower half
            assign node_v[g] = node_v[2*g] | node_v[2*g+1];
            assign node_i[g] = node_v[2*g] ? node_i[2*g] : node_i[2*g+1];
        end
    endgenerate

    assign o_found = node_v[1];
    assign o_idx   = node_i[1];

endmodule

/* hw/rtl/fol_cell.sv */
// One slot of the ordered table: holds a key and a count, shifts with neighbors.
// Depends on fol_pkg.
module fol_cell (
    input  logic                      i_clk,
    input  logic [fol_pkg::IDX_W-1:0] i_pos,
    input  fol_pkg::t_cell_ctrl       i_ctrl,
    input  fol_pkg::t_entry           i_left,
    input  fol_pkg::t_entry           i_right,
    output fol_pkg::t_entry           o_entry,
    output fol_pkg::t_entry           o_sel,
    output logic                      o_match,
    output logic                      o_cand
);
    import fol_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   used_here;

    assign used_here = USED_W'(i_pos) < i_ctrl.used;

    assign o_match = used_here && (r_entry.key == i_ctrl.new_entry.key);
    // candidate landing spot: not the moving entry, count not above the new one
    assign o_cand  = used_here && (i_pos != i_ctrl.hit)
                     && (r_entry.count <= i_ctrl.new_entry.count);

    assign o_sel   = (i_pos == i_ctrl.sel_pos) ? r_entry : '0;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            CELL_WRITE: begin
                if (i_pos == i_ctrl.ins) n_entry = i_ctrl.new_entry;
            end
            CELL_MOVE: begin
                if (i_pos == i_ctrl.ins) begin
                    n_entry = i_ctrl.new_entry;
                end else if (i_ctrl.ins < i_ctrl.hit && i_pos > i_ctrl.ins
                             && i_pos <= i_ctrl.hit) begin
                    n_entry = i_left;
                end else if (i_ctrl.ins > i_ctrl.hit && i_pos >= i_ctrl.hit
                             && i_pos < i_ctrl.ins) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
